// ----- hw/rtl/nbc_pkg.sv -----
// Shared types and codes for the Newton basin classifier.
package nbc_pkg;

    typedef logic [3:0] t_op;
    typedef logic [2:0] t_state;

    // Width of the exact product and sum datapath.
    localparam int WW = 128;

    // Product-pair operations run by the shared multiplier.
    localparam t_op OP_SR  = 4'd0;
    localparam t_op OP_SI  = 4'd1;
    localparam t_op OP_PR  = 4'd2;
    localparam t_op OP_PI  = 4'd3;
    localparam t_op OP_FR  = 4'd4;
    localparam t_op OP_FI  = 4'd5;
    localparam t_op OP_DEN = 4'd6;
    localparam t_op OP_NR  = 4'd7;
    localparam t_op OP_NI  = 4'd8;
    localparam t_op OP_D1  = 4'd9;
    localparam t_op OP_D2  = 4'd10;
    localparam t_op OP_D3  = 4'd11;

    localparam t_state ST_IDLE = 3'd0;
    localparam t_state ST_MUL  = 3'd1;
    localparam t_state ST_DIV  = 3'd2;
    localparam t_state ST_DFIN = 3'd3;
    localparam t_state ST_UPD  = 3'd4;
    localparam t_state ST_FIN  = 3'd5;

    localparam logic [2:0] CODE_FLAT  = 3'd0;
    localparam logic [2:0] CODE_ROOT1 = 3'd1;
    localparam logic [2:0] CODE_ROOT2 = 3'd2;
    localparam logic [2:0] CODE_ROOT3 = 3'd3;
    localparam logic [2:0] CODE_NONE  = 3'd4;

    localparam logic [1:0] CFG_TOL_SQ   = 2'd0;
    localparam logic [1:0] CFG_PREC_SQ  = 2'd1;
    localparam logic [1:0] CFG_MAX_ITER = 2'd2;

endpackage

// ----- hw/rtl/newton_basin_classifier_unit.sv -----
// Newton basin classifier: iterative fixed-point Newton solver for a complex cubic.
//
// A start point (i_start_real, i_start_imag, signed Q format) is taken as a request
// when i_valid is high and o_stall is low. o_stall stays high while one point is
// being worked on. The basin code leaves on o_valid/o_basin_code and is held until
// a cycle where i_stall is low; the next request may be taken meanwhile, and a
// finished code waits in its final state until the output register frees up.
// Configuration writes (i_cfg_valid, i_cfg_index, i_cfg_data) are always taken.
//
// One 32x32 multiplier, taking four partial products per exact product, evaluates every
// product pair in turn; one restoring divider gives one quotient bit a cycle.
// One Newton step runs nine product pairs (a flat derivative ends the point early), two
// divisions and an update, then up to three root tests; a point takes max_iter such
// steps at most.
// Reset clears the control state and loads the default thresholds.
module newton_basin_classifier_unit import nbc_pkg::*; #(
    parameter int COORD_WIDTH = 48,
    parameter int FRAC_BITS   = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_start_real,
    input  logic signed [COORD_WIDTH-1:0] i_start_imag,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_basin_code,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int DSTEPS = WW + FRAC_BITS;
    localparam int CNTW   = $clog2(DSTEPS + 1);

    localparam logic signed [WW-1:0] ONE    = 128'sd1 <<< FRAC_BITS;
    localparam logic signed [WW-1:0] MAXV   = (128'sd1 <<< (CW - 1)) - 128'sd1;
    localparam logic signed [WW-1:0] MINV   = -(128'sd1 <<< (CW - 1));
    localparam logic signed [WW-1:0] MAX128 = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] MIN128 = {1'b1, {(WW-1){1'b0}}};
    localparam logic [63:0]          QMAX   = 64'((65'd1 << (CW - 1)) - 65'd1);

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [WW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > MAXV) r = MAXV[CW-1:0];
        else if (v < MINV) r = MINV[CW-1:0];
        else r = v[CW-1:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sdiff(input logic signed [CW-1:0] a,
                                                   input logic signed [WW-1:0] b);
        return sat_cw(128'(a) - b);
    endfunction

    // Control and configuration registers.
    t_state              r_state;
    t_op                 r_op;
    logic [3:0]          r_ph;
    logic [7:0]          r_iter;
    logic [2:0]          r_code;
    logic [63:0]         r_tol;
    logic [63:0]         r_prec;
    logic [7:0]          r_maxit;
    logic                r_ovalid;
    logic [2:0]          r_ocode;
    logic                r_dsel;
    logic [CNTW-1:0]     r_dcnt;

    // Datapath registers.
    logic signed [CW-1:0] r_zr, r_zi, r_sr, r_si, r_pr, r_pi, r_fr, r_fi, r_qr, r_qi;
    logic [WW-1:0]        r_acc;
    logic signed [WW-1:0] r_p1, r_p2, r_nr, r_ni;
    logic [WW-1:0]        r_den;
    logic [WW-1:0]        r_rem;
    logic [DSTEPS-1:0]    r_dsh;
    logic [63:0]          r_q;
    logic                 r_ovf;
    logic                 r_dneg;

    // Derived complex values of the current step.
    logic signed [CW-1:0] dr, di, ar, ai, br, bi, cr, ci, dx, dy;
    logic signed [WW-1:0] rx, ry;

    assign dr = sat_cw(128'sd3 * 128'(r_sr) - 128'sd6 * 128'(r_zr) + 128'sd6 * 128'(r_zi));
    assign di = sat_cw(128'sd3 * 128'(r_si) - 128'sd6 * 128'(r_zr) - 128'sd6 * 128'(r_zi)
                       + 128'sd7 * ONE);
    assign ar = sdiff(r_zr, ONE);
    assign ai = r_zi;
    assign br = sdiff(r_zr, 128'sd2 * ONE);
    assign bi = sdiff(r_zi, ONE);
    assign cr = r_zr;
    assign ci = sdiff(r_zi, 128'sd2 * ONE);

    always_comb begin
        case (r_op)
            OP_D1: begin
                rx = ONE;
                ry = '0;
            end
            OP_D2: begin
                rx = 128'sd2 * ONE;
                ry = ONE;
            end
            default: begin
                rx = '0;
                ry = 128'sd2 * ONE;
            end
        endcase
    end
    assign dx = sdiff(r_zr, rx);
    assign dy = sdiff(r_zi, ry);

    // Operand selection for the product pair a1*b1 +/- a2*b2.
    logic signed [CW-1:0] a1, b1, a2, b2;
    logic                 sub;

    always_comb begin
        sub = 1'b0;
        case (r_op)
            OP_SR: begin
                a1 = r_zr; b1 = r_zr; a2 = r_zi; b2 = r_zi; sub = 1'b1;
            end
            OP_SI: begin
                a1 = r_zr; b1 = r_zi; a2 = r_zi; b2 = r_zr;
            end
            OP_PR: begin
                a1 = ar; b1 = br; a2 = ai; b2 = bi; sub = 1'b1;
            end
            OP_PI: begin
                a1 = ar; b1 = bi; a2 = ai; b2 = br;
            end
            OP_FR: begin
                a1 = r_pr; b1 = cr; a2 = r_pi; b2 = ci; sub = 1'b1;
            end
            OP_FI: begin
                a1 = r_pr; b1 = ci; a2 = r_pi; b2 = cr;
            end
            OP_DEN: begin
                a1 = dr; b1 = dr; a2 = di; b2 = di;
            end
            OP_NR: begin
                a1 = r_fr; b1 = dr; a2 = r_fi; b2 = di;
            end
            OP_NI: begin
                a1 = r_fi; b1 = dr; a2 = r_fr; b2 = di; sub = 1'b1;
            end
            default: begin
                a1 = dx; b1 = dx; a2 = dy; b2 = dy;
            end
        endcase
    end

    // Shared multiplier: one 32x32 partial product per cycle.
    logic signed [63:0] opa, opb;
    logic [63:0]        ua, ub, pp;
    logic [31:0]        pa, pb;
    logic [WW-1:0]      pp_sh, acc_sum;
    logic signed [WW-1:0] prod_s;

    assign opa = r_ph[2] ? 64'(a2) : 64'(a1);
    assign opb = r_ph[2] ? 64'(b2) : 64'(b1);
    assign ua  = opa[63] ? (~opa + 64'd1) : opa;
    assign ub  = opb[63] ? (~opb + 64'd1) : opb;

    always_comb begin
        case (r_ph[1:0])
            2'd0: begin
                pa = ua[31:0]; pb = ub[31:0];
            end
            2'd1: begin
                pa = ua[31:0]; pb = ub[63:32];
            end
            2'd2: begin
                pa = ua[63:32]; pb = ub[31:0];
            end
            default: begin
                pa = ua[63:32]; pb = ub[63:32];
            end
        endcase
    end

    assign pp = 64'(pa) * 64'(pb);

    always_comb begin
        case (r_ph[1:0])
            2'd0:    pp_sh = 128'(pp);
            2'd3:    pp_sh = 128'(pp) << 64;
            default: pp_sh = 128'(pp) << 32;
        endcase
    end

    assign acc_sum = ((r_ph[1:0] == 2'd0) ? '0 : r_acc) + pp_sh;
    assign prod_s  = (opa[63] ^ opb[63]) ? -$signed(acc_sum) : $signed(acc_sum);

    // Combination of the two products.
    logic signed [WW-1:0] p2n, sraw, ssum, sshift;
    logic [WW-1:0]        usum, tlim;
    logic                 sovf;
    logic signed [CW-1:0] res_cw;

    assign p2n    = sub ? -r_p2 : r_p2;
    assign sraw   = r_p1 + p2n;
    assign sovf   = (r_p1[WW-1] == p2n[WW-1]) && (sraw[WW-1] != r_p1[WW-1]);
    assign ssum   = sovf ? (r_p1[WW-1] ? MIN128 : MAX128) : sraw;
    assign sshift = ssum >>> FRAC_BITS;
    assign res_cw = sat_cw(sshift);
    assign usum   = unsigned'(r_p1) + unsigned'(r_p2);
    assign tlim   = 128'(r_tol) << FRAC_BITS;

    // Divider: numerator magnitude, restoring step and final saturation.
    logic signed [WW-1:0] dnum;
    logic [WW-1:0]        dmag, rem2;
    logic                 dge;
    logic [63:0]          qlim, qcap;
    logic signed [CW-1:0] qres;

    assign dnum = (r_state == ST_MUL) ? r_nr : r_ni;
    assign dmag = dnum[WW-1] ? (~unsigned'(dnum) + 128'd1) : unsigned'(dnum);
    assign rem2 = {r_rem[WW-2:0], r_dsh[DSTEPS-1]};
    assign dge  = rem2 >= r_den;
    assign qlim = r_dneg ? (QMAX + 64'd1) : QMAX;
    assign qcap = (r_ovf || (r_q > qlim)) ? qlim : r_q;
    assign qres = r_dneg ? -$signed(qcap[CW-1:0]) : $signed(qcap[CW-1:0]);

    logic [7:0] n_iter;
    assign n_iter = r_iter + 8'd1;

    // A finished code moves to the output register once that register is free.
    logic fin_go;
    assign fin_go = (r_state == ST_FIN) && (!r_ovalid || !i_stall);

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_ovalid;
    assign o_basin_code = r_ocode;
    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_SR;
            r_ph     <= '0;
            r_iter   <= '0;
            r_code   <= CODE_NONE;
            r_tol    <= 64'd109951163;
            r_prec   <= 64'd12089258;
            r_maxit  <= 8'd12;
            r_ovalid <= 1'b0;
            r_dsel   <= 1'b0;
            r_dcnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TOL_SQ:   r_tol   <= i_cfg_data;
                    CFG_PREC_SQ:  r_prec  <= i_cfg_data;
                    CFG_MAX_ITER: r_maxit <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (fin_go) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_zr   <= i_start_real;
                        r_zi   <= i_start_imag;
                        r_iter <= '0;
                        r_op   <= OP_SR;
                        r_ph   <= '0;
                        if (r_maxit == 8'd0) begin
                            r_code  <= CODE_NONE;
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_acc <= acc_sum;
                    r_ph  <= r_ph + 4'd1;
                    if (r_ph == 4'd3) r_p1 <= prod_s;
                    if (r_ph == 4'd7) r_p2 <= prod_s;
                    if (r_ph == 4'd8) begin
                        r_ph <= '0;
                        case (r_op)
                            OP_SR: begin
                                r_sr <= res_cw; r_op <= OP_SI;
                            end
                            OP_SI: begin
                                r_si <= res_cw; r_op <= OP_PR;
                            end
                            OP_PR: begin
                                r_pr <= res_cw; r_op <= OP_PI;
                            end
                            OP_PI: begin
                                r_pi <= res_cw; r_op <= OP_FR;
                            end
                            OP_FR: begin
                                r_fr <= res_cw; r_op <= OP_FI;
                            end
                            OP_FI: begin
                                r_fi <= res_cw; r_op <= OP_DEN;
                            end
                            OP_DEN: begin
                                r_den <= usum;
                                // A zero derivative counts as flat whatever the threshold.
                                if ((usum == '0) || (usum < tlim)) begin
                                    r_code  <= CODE_FLAT;
                                    r_state <= ST_FIN;
                                end else begin
                                    r_op <= OP_NR;
                                end
                            end
                            OP_NR: begin
                                r_nr <= ssum; r_op <= OP_NI;
                            end
                            OP_NI: begin
                                r_ni    <= ssum;
                                r_dsel  <= 1'b0;
                                r_dneg  <= dnum[WW-1];
                                r_dsh   <= {dmag, {FRAC_BITS{1'b0}}};
                                r_rem   <= '0;
                                r_q     <= '0;
                                r_ovf   <= 1'b0;
                                r_dcnt  <= CNTW'(DSTEPS);
                                r_state <= ST_DIV;
                            end
                            OP_D1: begin
                                if (usum < 128'(r_prec)) begin
                                    r_code <= CODE_ROOT1; r_state <= ST_FIN;
                                end else begin
                                    r_op <= OP_D2;
                                end
                            end
                            OP_D2: begin
                                if (usum < 128'(r_prec)) begin
                                    r_code <= CODE_ROOT2; r_state <= ST_FIN;
                                end else begin
                                    r_op <= OP_D3;
                                end
                            end
                            default: begin
                                r_iter <= n_iter;
                                r_op   <= OP_SR;
                                if (usum < 128'(r_prec)) begin
                                    r_code <= CODE_ROOT3; r_state <= ST_FIN;
                                end else if (n_iter == r_maxit) begin
                                    r_code <= CODE_NONE; r_state <= ST_FIN;
                                end
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_dsh  <= r_dsh << 1;
                    r_ovf  <= r_ovf | r_q[63];
                    r_rem  <= dge ? (rem2 - r_den) : rem2;
                    r_q    <= {r_q[62:0], dge};
                    r_dcnt <= r_dcnt - CNTW'(1);
                    if (r_dcnt == CNTW'(1)) r_state <= ST_DFIN;
                end
                ST_DFIN: begin
                    if (!r_dsel) begin
                        r_qr    <= qres;
                        r_dsel  <= 1'b1;
                        r_dneg  <= dnum[WW-1];
                        r_dsh   <= {dmag, {FRAC_BITS{1'b0}}};
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_ovf   <= 1'b0;
                        r_dcnt  <= CNTW'(DSTEPS);
                        r_state <= ST_DIV;
                    end else begin
                        r_qi    <= qres;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_zr    <= sdiff(r_zr, 128'(r_qr));
                    r_zi    <= sdiff(r_zi, 128'(r_qi));
                    r_op    <= OP_D1;
                    r_ph    <= '0;
                    r_state <= ST_MUL;
                end
                ST_FIN: begin
                    if (fin_go) begin
                        r_ocode  <= r_code;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
